[hw/rtl/assert_macros.svh]
// Assertion macros for the filter RTL; kpv_seq uses them.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define KPV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define KPV_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/kpv_pkg.sv]
// Shared types, codes and the microcode program of the position/velocity filter.
// No dependencies; used by every module of the block.
package kpv_pkg;

  localparam int DW  = 64;
  localparam int TW  = 63;
  localparam int AW  = 5;
  localparam int OW  = 6;
  localparam int PCW = 7;
  localparam int CIW = 3;

  typedef logic [DW-1:0] word_t;

  localparam word_t FX_ONE = 64'h0000_0001_0000_0000;

  // operations
  localparam logic [3:0] OP_ADD       = 4'd0;
  localparam logic [3:0] OP_SUB       = 4'd1;
  localparam logic [3:0] OP_MUL       = 4'd2;
  localparam logic [3:0] OP_DIV       = 4'd3;
  localparam logic [3:0] OP_SHR       = 4'd4;
  localparam logic [3:0] OP_MOV       = 4'd5;
  localparam logic [3:0] OP_MOVNZ     = 4'd6;
  localparam logic [3:0] OP_DONE      = 4'd7;
  localparam logic [3:0] OP_DONE_SKIP = 4'd8;

  // jump conditions
  localparam logic [1:0] JC_NONE   = 2'd0;
  localparam logic [1:0] JC_ZERO   = 2'd1;
  localparam logic [1:0] JC_ALWAYS = 2'd2;

  // configuration register indexes
  localparam logic [CIW-1:0] CFG_POS  = 3'd0;
  localparam logic [CIW-1:0] CFG_VEL  = 3'd1;
  localparam logic [CIW-1:0] CFG_TIME = 3'd2;
  localparam logic [CIW-1:0] CFG_PSTD = 3'd3;
  localparam logic [CIW-1:0] CFG_ASTD = 3'd4;

  // register file slots (operand codes with the top bit clear)
  localparam logic [OW-1:0] R_POS  = 6'd0;
  localparam logic [OW-1:0] R_VEL  = 6'd1;
  localparam logic [OW-1:0] R_P0   = 6'd2;
  localparam logic [OW-1:0] R_P1   = 6'd3;
  localparam logic [OW-1:0] R_P2   = 6'd4;
  localparam logic [OW-1:0] R_P3   = 6'd5;
  localparam logic [OW-1:0] R_LT   = 6'd6;
  localparam logic [OW-1:0] R_PSTD = 6'd7;
  localparam logic [OW-1:0] R_ASTD = 6'd8;
  localparam logic [OW-1:0] R_T1   = 6'd9;
  localparam logic [OW-1:0] R_T2   = 6'd10;
  localparam logic [OW-1:0] R_DT   = 6'd11;
  localparam logic [OW-1:0] R_B0   = 6'd12;
  localparam logic [OW-1:0] R_Q    = 6'd13;
  localparam logic [OW-1:0] R_M00  = 6'd14;
  localparam logic [OW-1:0] R_R0   = 6'd11;
  localparam logic [OW-1:0] R_S00  = 6'd12;
  localparam logic [OW-1:0] R_S11  = 6'd13;
  localparam logic [OW-1:0] R_DET  = 6'd14;
  localparam logic [OW-1:0] R_I00  = 6'd15;
  localparam logic [OW-1:0] R_I01  = 6'd16;
  localparam logic [OW-1:0] R_I10  = 6'd17;
  localparam logic [OW-1:0] R_I11  = 6'd18;
  localparam logic [OW-1:0] R_K00  = 6'd19;
  localparam logic [OW-1:0] R_K01  = 6'd20;
  localparam logic [OW-1:0] R_K10  = 6'd21;
  localparam logic [OW-1:0] R_K11  = 6'd22;
  localparam logic [OW-1:0] R_Y0   = 6'd23;
  localparam logic [OW-1:0] R_Y1   = 6'd24;
  localparam logic [OW-1:0] R_N00  = 6'd25;
  localparam logic [OW-1:0] R_N01  = 6'd26;
  localparam logic [OW-1:0] R_N10  = 6'd27;
  localparam logic [OW-1:0] R_N11  = 6'd28;
  localparam logic [OW-1:0] R_NP0  = 6'd29;
  localparam logic [OW-1:0] R_NP1  = 6'd30;
  localparam logic [OW-1:0] R_NP2  = 6'd31;

  // operands taken from the captured item or constants
  localparam logic [OW-1:0] O_ACC  = 6'd32;
  localparam logic [OW-1:0] O_TNOW = 6'd33;
  localparam logic [OW-1:0] O_ZP   = 6'd34;
  localparam logic [OW-1:0] O_ZV   = 6'd35;
  localparam logic [OW-1:0] O_PE   = 6'd36;
  localparam logic [OW-1:0] O_VE   = 6'd37;
  localparam logic [OW-1:0] O_ONE  = 6'd38;
  localparam logic [OW-1:0] O_ZERO = 6'd39;

  // program entry points
  localparam logic [PCW-1:0] PC_PRD    = 7'd0;
  localparam logic [PCW-1:0] PC_DONE   = 7'd21;
  localparam logic [PCW-1:0] PC_SKIP   = 7'd22;
  localparam logic [PCW-1:0] PC_UPD    = 7'd23;
  localparam logic [PCW-1:0] PROG_LAST = 7'd77;

  typedef struct packed {
    logic [3:0]     op;
    logic [OW-1:0]  dst;
    logic [OW-1:0]  a;
    logic [OW-1:0]  b;
    logic [1:0]     jc;
    logic [PCW-1:0] tgt;
  } cw_t;

  typedef struct packed {
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
  } rf_rd_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    word_t         data;
  } rf_wr_t;

  typedef struct packed {
    logic       start;
    logic [3:0] op;
    word_t      a;
    word_t      b;
  } alu_req_t;

  typedef struct packed {
    logic  done;
    word_t result;
  } alu_rsp_t;

  typedef struct packed {
    word_t          acc;
    logic [TW-1:0]  tnow;
    word_t          zp;
    word_t          zv;
    logic [TW-1:0]  pe;
    logic [TW-1:0]  ve;
  } in_item_t;

  typedef struct packed {
    logic  load;
    logic  skip;
    word_t pos;
    word_t vel;
  } fin_t;

  function automatic cw_t cw(input logic [3:0] op, input logic [OW-1:0] dst,
                             input logic [OW-1:0] a, input logic [OW-1:0] b,
                             input logic [1:0] jc, input logic [PCW-1:0] tgt);
    cw_t w;
    w.op  = op;
    w.dst = dst;
    w.a   = a;
    w.b   = b;
    w.jc  = jc;
    w.tgt = tgt;
    return w;
  endfunction

  function automatic cw_t rom_word(input logic [PCW-1:0] pc);
    cw_t w;
    case (pc)
      // predict
      7'd0:  w = cw(OP_SUB,  R_DT,  O_TNOW, R_LT,   JC_NONE, '0);
      7'd1:  w = cw(OP_MUL,  R_T1,  R_DT,   R_DT,   JC_NONE, '0);
      7'd2:  w = cw(OP_SHR,  R_B0,  R_T1,   O_ZERO, JC_NONE, '0);
      7'd3:  w = cw(OP_MUL,  R_Q,   R_ASTD, R_ASTD, JC_NONE, '0);
      7'd4:  w = cw(OP_MUL,  R_T1,  R_DT,   R_VEL,  JC_NONE, '0);
      7'd5:  w = cw(OP_ADD,  R_T2,  R_POS,  R_T1,   JC_NONE, '0);
      7'd6:  w = cw(OP_MUL,  R_T1,  R_B0,   O_ACC,  JC_NONE, '0);
      7'd7:  w = cw(OP_ADD,  R_POS, R_T2,   R_T1,   JC_NONE, '0);
      7'd8:  w = cw(OP_MUL,  R_T1,  R_DT,   O_ACC,  JC_NONE, '0);
      7'd9:  w = cw(OP_ADD,  R_VEL, R_VEL,  R_T1,   JC_NONE, '0);
      7'd10: w = cw(OP_MUL,  R_T1,  R_DT,   R_P2,   JC_NONE, '0);
      7'd11: w = cw(OP_ADD,  R_M00, R_P0,   R_T1,   JC_NONE, '0);
      7'd12: w = cw(OP_MUL,  R_T1,  R_DT,   R_P3,   JC_NONE, '0);
      7'd13: w = cw(OP_ADD,  R_P1,  R_P1,   R_T1,   JC_NONE, '0);
      7'd14: w = cw(OP_MUL,  R_T1,  R_P1,   R_DT,   JC_NONE, '0);
      7'd15: w = cw(OP_ADD,  R_T2,  R_M00,  R_T1,   JC_NONE, '0);
      7'd16: w = cw(OP_ADD,  R_P0,  R_T2,   R_Q,    JC_NONE, '0);
      7'd17: w = cw(OP_MUL,  R_T1,  R_P3,   R_DT,   JC_NONE, '0);
      7'd18: w = cw(OP_ADD,  R_P2,  R_P2,   R_T1,   JC_NONE, '0);
      7'd19: w = cw(OP_ADD,  R_P3,  R_P3,   R_Q,    JC_NONE, '0);
      7'd20: w = cw(OP_MOV,  R_LT,  O_TNOW, O_ZERO, JC_NONE, '0);
      // result steps
      7'd21: w = cw(OP_DONE,      R_POS, R_POS, R_VEL, JC_NONE, '0);
      7'd22: w = cw(OP_DONE_SKIP, R_POS, R_POS, R_VEL, JC_NONE, '0);
      // update
      7'd23: w = cw(OP_MOVNZ, R_PSTD, O_PE,   O_ZERO, JC_NONE, '0);
      7'd24: w = cw(OP_MUL,   R_R0,   R_PSTD, R_PSTD, JC_NONE, '0);
      7'd25: w = cw(OP_ADD,   R_S00,  R_P0,   R_R0,   JC_NONE, '0);
      7'd26: w = cw(OP_MUL,   R_T1,   O_VE,   O_VE,   JC_NONE, '0);
      7'd27: w = cw(OP_ADD,   R_S11,  R_P3,   R_T1,   JC_NONE, '0);
      7'd28: w = cw(OP_MUL,   R_T1,   R_S00,  R_S11,  JC_NONE, '0);
      7'd29: w = cw(OP_MUL,   R_T2,   R_P1,   R_P2,   JC_NONE, '0);
      7'd30: w = cw(OP_SUB,   R_DET,  R_T1,   R_T2,   JC_ZERO, PC_SKIP);
      7'd31: w = cw(OP_DIV,   R_I00,  R_S11,  R_DET,  JC_NONE, '0);
      7'd32: w = cw(OP_SUB,   R_T1,   O_ZERO, R_P1,   JC_NONE, '0);
      7'd33: w = cw(OP_DIV,   R_I01,  R_T1,   R_DET,  JC_NONE, '0);
      7'd34: w = cw(OP_SUB,   R_T1,   O_ZERO, R_P2,   JC_NONE, '0);
      7'd35: w = cw(OP_DIV,   R_I10,  R_T1,   R_DET,  JC_NONE, '0);
      7'd36: w = cw(OP_DIV,   R_I11,  R_S00,  R_DET,  JC_NONE, '0);
      7'd37: w = cw(OP_MUL,   R_T1,   R_P0,   R_I00,  JC_NONE, '0);
      7'd38: w = cw(OP_MUL,   R_T2,   R_P1,   R_I10,  JC_NONE, '0);
      7'd39: w = cw(OP_ADD,   R_K00,  R_T1,   R_T2,   JC_NONE, '0);
      7'd40: w = cw(OP_MUL,   R_T1,   R_P0,   R_I01,  JC_NONE, '0);
      7'd41: w = cw(OP_MUL,   R_T2,   R_P1,   R_I11,  JC_NONE, '0);
      7'd42: w = cw(OP_ADD,   R_K01,  R_T1,   R_T2,   JC_NONE, '0);
      7'd43: w = cw(OP_MUL,   R_T1,   R_P2,   R_I00,  JC_NONE, '0);
      7'd44: w = cw(OP_MUL,   R_T2,   R_P3,   R_I10,  JC_NONE, '0);
      7'd45: w = cw(OP_ADD,   R_K10,  R_T1,   R_T2,   JC_NONE, '0);
      7'd46: w = cw(OP_MUL,   R_T1,   R_P2,   R_I01,  JC_NONE, '0);
      7'd47: w = cw(OP_MUL,   R_T2,   R_P3,   R_I11,  JC_NONE, '0);
      7'd48: w = cw(OP_ADD,   R_K11,  R_T1,   R_T2,   JC_NONE, '0);
      7'd49: w = cw(OP_SUB,   R_Y0,   O_ZP,   R_POS,  JC_NONE, '0);
      7'd50: w = cw(OP_SUB,   R_Y1,   O_ZV,   R_VEL,  JC_NONE, '0);
      7'd51: w = cw(OP_MUL,   R_T1,   R_K00,  R_Y0,   JC_NONE, '0);
      7'd52: w = cw(OP_MUL,   R_T2,   R_K01,  R_Y1,   JC_NONE, '0);
      7'd53: w = cw(OP_ADD,   R_T1,   R_T1,   R_T2,   JC_NONE, '0);
      7'd54: w = cw(OP_ADD,   R_POS,  R_POS,  R_T1,   JC_NONE, '0);
      7'd55: w = cw(OP_MUL,   R_T1,   R_K10,  R_Y0,   JC_NONE, '0);
      7'd56: w = cw(OP_MUL,   R_T2,   R_K11,  R_Y1,   JC_NONE, '0);
      7'd57: w = cw(OP_ADD,   R_T1,   R_T1,   R_T2,   JC_NONE, '0);
      7'd58: w = cw(OP_ADD,   R_VEL,  R_VEL,  R_T1,   JC_NONE, '0);
      7'd59: w = cw(OP_SUB,   R_N00,  O_ONE,  R_K00,  JC_NONE, '0);
      7'd60: w = cw(OP_SUB,   R_N01,  O_ZERO, R_K01,  JC_NONE, '0);
      7'd61: w = cw(OP_SUB,   R_N10,  O_ZERO, R_K10,  JC_NONE, '0);
      7'd62: w = cw(OP_SUB,   R_N11,  O_ONE,  R_K11,  JC_NONE, '0);
      7'd63: w = cw(OP_MUL,   R_T1,   R_N00,  R_P0,   JC_NONE, '0);
      7'd64: w = cw(OP_MUL,   R_T2,   R_N01,  R_P2,   JC_NONE, '0);
      7'd65: w = cw(OP_ADD,   R_NP0,  R_T1,   R_T2,   JC_NONE, '0);
      7'd66: w = cw(OP_MUL,   R_T1,   R_N00,  R_P1,   JC_NONE, '0);
      7'd67: w = cw(OP_MUL,   R_T2,   R_N01,  R_P3,   JC_NONE, '0);
      7'd68: w = cw(OP_ADD,   R_NP1,  R_T1,   R_T2,   JC_NONE, '0);
      7'd69: w = cw(OP_MUL,   R_T1,   R_N10,  R_P0,   JC_NONE, '0);
      7'd70: w = cw(OP_MUL,   R_T2,   R_N11,  R_P2,   JC_NONE, '0);
      7'd71: w = cw(OP_ADD,   R_NP2,  R_T1,   R_T2,   JC_NONE, '0);
      7'd72: w = cw(OP_MUL,   R_T1,   R_N10,  R_P1,   JC_NONE, '0);
      7'd73: w = cw(OP_MUL,   R_T2,   R_N11,  R_P3,   JC_NONE, '0);
      7'd74: w = cw(OP_ADD,   R_P3,   R_T1,   R_T2,   JC_NONE, '0);
      7'd75: w = cw(OP_MOV,   R_P0,   R_NP0,  O_ZERO, JC_NONE, '0);
      7'd76: w = cw(OP_MOV,   R_P1,   R_NP1,  O_ZERO, JC_NONE, '0);
      7'd77: w = cw(OP_MOV,   R_P2,   R_NP2,  O_ZERO, JC_ALWAYS, PC_DONE);
      default: w = cw(OP_DONE, R_POS, R_POS, R_VEL, JC_NONE, '0);
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/kpv_regfile.sv]
// Filter state and scratch register file: one write port, two registered read ports.
// Depends on kpv_pkg. Valid bits give the reset values until an entry is written.
module kpv_regfile (
  input  logic            clk,
  input  logic            rst_n,
  input  kpv_pkg::rf_rd_t rd,
  input  kpv_pkg::rf_wr_t wr,
  output kpv_pkg::word_t  rd_a,
  output kpv_pkg::word_t  rd_b
);
  import kpv_pkg::*;

  localparam int DEPTH = 1 << AW;

  word_t             mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  word_t             rd_a_r;
  word_t             rd_b_r;

  // covariance diagonal starts at one, everything else at zero
  function automatic word_t rst_val(input logic [AW-1:0] addr);
    return (addr == R_P0[AW-1:0] || addr == R_P3[AW-1:0]) ? FX_ONE : '0;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.we) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_a_r <= valid_r[rd.addr_a] ? mem[rd.addr_a] : rst_val(rd.addr_a);
    rd_b_r <= valid_r[rd.addr_b] ? mem[rd.addr_b] : rst_val(rd.addr_b);
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

[hw/rtl/kpv_alu.sv]
// Shared Q31.32 arithmetic unit: saturating add/sub, shift, move,
// a 32x32 partial product multiplier and a bit-serial divider.
// Depends on kpv_pkg.
module kpv_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  kpv_pkg::alu_req_t req,
  output kpv_pkg::alu_rsp_t rsp
);
  import kpv_pkg::*;

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_MUL  = 3'd1;
  localparam logic [2:0] A_MRND = 3'd2;
  localparam logic [2:0] A_MSAT = 3'd3;
  localparam logic [2:0] A_DIV  = 3'd4;
  localparam logic [2:0] A_DSAT = 3'd5;

  localparam word_t SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam word_t SMIN = {1'b1, {(DW-1){1'b0}}};
  localparam int    QBITS = DW + 32;

  logic [2:0]        st_r;
  logic [6:0]        cnt_r;
  logic              done_r;
  word_t             res_r;
  word_t             x_r;
  word_t             y_r;
  logic [2*DW-1:0]   acc_r;
  logic [QBITS-1:0]  dvd_r;
  word_t             rem_r;
  word_t             q_r;
  logic              neg_r;
  logic              over_r;

  function automatic word_t mag(input word_t v);
    return v[DW-1] ? (~v + 64'd1) : v;
  endfunction

  function automatic word_t from_mag(input word_t m, input logic neg, input logic over);
    word_t r;
    if (neg) begin
      r = (over || m[DW-1]) ? SMIN : (~m + 64'd1);
    end else begin
      r = (over || m[DW-1]) ? SMAX : m;
    end
    return r;
  endfunction

  function automatic word_t sat65(input logic [DW:0] s);
    word_t r;
    if (s[DW] != s[DW-1]) begin
      r = s[DW] ? SMIN : SMAX;
    end else begin
      r = s[DW-1:0];
    end
    return r;
  endfunction

  word_t           simple_res;
  logic [DW-1:0]   pp;
  logic [2*DW-1:0] addend;
  word_t           rs;
  logic            ge;

  always_comb begin
    case (req.op)
      OP_ADD:  simple_res = sat65({req.a[DW-1], req.a} + {req.b[DW-1], req.b});
      OP_SUB:  simple_res = sat65({req.a[DW-1], req.a} - {req.b[DW-1], req.b});
      OP_SHR:  simple_res = {1'b0, req.a[DW-1:1]};
      default: simple_res = req.a;
    endcase
  end

  // partial product order: lo*lo, lo*hi, hi*lo, hi*hi
  always_comb begin
    pp = (cnt_r[1] ? x_r[DW-1:32] : x_r[31:0]) * (cnt_r[0] ? y_r[DW-1:32] : y_r[31:0]);
    case (cnt_r[1:0])
      2'd0:    addend = {64'd0, pp};
      2'd3:    addend = {pp, 64'd0};
      default: addend = {32'd0, pp, 32'd0};
    endcase
  end

  always_comb begin
    rs = {rem_r[DW-2:0], dvd_r[QBITS-1]};
    ge = (rs >= y_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        A_IDLE: begin
          if (req.start) begin
            neg_r <= req.a[DW-1] ^ req.b[DW-1];
            x_r   <= mag(req.a);
            y_r   <= mag(req.b);
            cnt_r <= '0;
            if (req.op == OP_MUL) begin
              acc_r <= '0;
              st_r  <= A_MUL;
            end else if (req.op == OP_DIV) begin
              dvd_r  <= {mag(req.a), 32'd0};
              rem_r  <= '0;
              q_r    <= '0;
              over_r <= 1'b0;
              st_r   <= A_DIV;
            end else begin
              res_r  <= simple_res;
              done_r <= 1'b1;
            end
          end
        end
        A_MUL: begin
          acc_r <= acc_r + addend;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r[1:0] == 2'd3) begin
            st_r <= A_MRND;
          end
        end
        A_MRND: begin
          // round half away from zero on the magnitude
          acc_r <= acc_r + {96'd0, 32'h8000_0000};
          st_r  <= A_MSAT;
        end
        A_MSAT: begin
          res_r  <= from_mag(acc_r[DW+31:32], neg_r, |acc_r[2*DW-1:DW+32]);
          done_r <= 1'b1;
          st_r   <= A_IDLE;
        end
        A_DIV: begin
          dvd_r <= {dvd_r[QBITS-2:0], 1'b0};
          rem_r <= ge ? (rs - y_r) : rs;
          q_r   <= {q_r[DW-2:0], ge};
          if (q_r[DW-1]) begin
            over_r <= 1'b1;
          end
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'(QBITS - 1)) begin
            st_r <= A_DSAT;
          end
        end
        A_DSAT: begin
          res_r  <= from_mag(q_r, neg_r, over_r);
          done_r <= 1'b1;
          st_r   <= A_IDLE;
        end
        default: st_r <= A_IDLE;
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

[hw/rtl/kpv_seq.sv]
// Microcode sequencer: steps through the program table, feeds the ALU,
// writes results back and takes conditional jumps. Depends on kpv_pkg.
`include "assert_macros.svh"
module kpv_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [6:0]            entry,
  input  kpv_pkg::in_item_t     item,
  input  kpv_pkg::word_t        rd_a,
  input  kpv_pkg::word_t        rd_b,
  output kpv_pkg::rf_rd_t       rd,
  output kpv_pkg::rf_wr_t       wr,
  output kpv_pkg::alu_req_t     req,
  input  kpv_pkg::alu_rsp_t     rsp,
  input  logic                  out_free,
  output kpv_pkg::fin_t         fin,
  output logic                  idle
);
  import kpv_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EX   = 2'd2;
  localparam logic [1:0] S_WAIT = 2'd3;

  logic [1:0]     state_r, state_nxt;
  logic [PCW-1:0] pc_r, pc_nxt;
  cw_t            w;
  word_t          opa, opb;
  logic           is_done;
  logic           jump;

  function automatic word_t special(input logic [OW-1:0] code, input in_item_t it);
    word_t v;
    case (code)
      O_ACC:   v = it.acc;
      O_TNOW:  v = {1'b0, it.tnow};
      O_ZP:    v = it.zp;
      O_ZV:    v = it.zv;
      O_PE:    v = {1'b0, it.pe};
      O_VE:    v = {1'b0, it.ve};
      O_ONE:   v = FX_ONE;
      O_ZERO:  v = '0;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign w       = rom_word(pc_r);
  assign opa     = w.a[OW-1] ? special(w.a, item) : rd_a;
  assign opb     = w.b[OW-1] ? special(w.b, item) : rd_b;
  assign is_done = (w.op == OP_DONE) || (w.op == OP_DONE_SKIP);
  assign jump    = (w.jc == JC_ALWAYS) || ((w.jc == JC_ZERO) && (rsp.result == '0));

  always_comb begin
    state_nxt   = state_r;
    pc_nxt      = pc_r;
    rd.addr_a   = w.a[AW-1:0];
    rd.addr_b   = w.b[AW-1:0];
    wr.we       = 1'b0;
    wr.addr     = w.dst[AW-1:0];
    wr.data     = rsp.result;
    req.start   = 1'b0;
    req.op      = w.op;
    req.a       = opa;
    req.b       = opb;
    fin.load    = 1'b0;
    fin.skip    = (w.op == OP_DONE_SKIP);
    fin.pos     = opa;
    fin.vel     = opb;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          pc_nxt    = entry;
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_EX;
      S_EX: begin
        if (is_done) begin
          if (out_free) begin
            fin.load  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          req.start = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (rsp.done) begin
          // conditional move leaves the slot alone on a zero operand
          wr.we     = (w.op != OP_MOVNZ) || (rsp.result != '0);
          pc_nxt    = jump ? w.tgt : pc_r + 7'd1;
          state_nxt = S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= PC_PRD;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);

  `KPV_ASSERT_RST(a_done_in_wait, rsp.done |-> state_r == S_WAIT, "ALU result outside wait")
  `KPV_ASSERT_RST(a_pc_in_prog, state_r != S_IDLE |-> pc_r <= PROG_LAST, "step counter off program")
  `KPV_ASSERT_RST(a_idle_after_result, $rose(state_r == S_IDLE) |-> $past(fin.load), "idle without result")

endmodule

[hw/rtl/kalman_position_velocity_axis.sv]
// Top level of the single-axis position/velocity filter.
// Depends on kpv_pkg, kpv_regfile, kpv_alu and kpv_seq.
// Input channel (in_valid/in_ready): one item per transfer; operation 0 is a
//   predict (acceleration, time_now), 1 an update (GPS position, velocity and
//   their errors). Each item gives exactly one result on the output channel
//   (out_valid/out_ready): position, velocity and a flag set when an update
//   met a singular innovation covariance.
// Configuration: cfg_we writes cfg_data to register cfg_index at once;
//   indexes 0..4 also load the matching state. Write only while idle.
// Timing: a microcoded program runs on one shared ALU. A multiply step sums
//   four 32x32 partial products, then rounds and saturates; a divide step
//   forms one quotient bit per cycle over 96 bits. One item in flight at a
//   time; in_ready is high while the sequencer is idle, from the cycle after
//   a result loads.
// Reset: synchronous, active low; in_ready held low, zero estimates and an
//   identity covariance. When the receiver stalls the finished result holds
//   in the output register and the next item may still be taken; that item
//   waits on its result step until the output register frees.
module kalman_position_velocity_axis (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic signed [63:0] in_acceleration,
  input  logic        [62:0] in_time_now,
  input  logic signed [63:0] in_measured_position,
  input  logic signed [63:0] in_measured_velocity,
  input  logic        [62:0] in_position_error,
  input  logic        [62:0] in_velocity_error,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_estimated_position,
  output logic signed [63:0] out_estimated_velocity,
  output logic               out_update_skipped,
  input  logic               cfg_we,
  input  logic        [2:0]  cfg_index,
  input  logic        [63:0] cfg_data
);
  import kpv_pkg::*;

  in_item_t  item_r;
  rf_rd_t    rf_rd;
  rf_wr_t    seq_wr, cfg_wr, rf_wr;
  word_t     rd_a, rd_b;
  alu_req_t  alu_req;
  alu_rsp_t  alu_rsp;
  fin_t      fin;
  logic      seq_idle;
  logic      in_xfer;
  logic      out_free;
  logic      out_valid_r;
  word_t     out_pos_r, out_vel_r;
  logic      out_skip_r;

  assign in_ready = seq_idle && rst_n;
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // capture the item; the program reads its fields as operands
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.acc  <= in_acceleration;
      item_r.tnow <= in_time_now;
      item_r.zp   <= in_measured_position;
      item_r.zv   <= in_measured_velocity;
      item_r.pe   <= in_position_error;
      item_r.ve   <= in_velocity_error;
    end
  end

  // configuration lands straight in the state slots; the position variance
  // is kept as its standard deviation and squared on each update
  always_comb begin
    cfg_wr.we   = cfg_we;
    cfg_wr.addr = R_POS[AW-1:0];
    cfg_wr.data = cfg_data;
    case (cfg_index)
      CFG_POS:  cfg_wr.addr = R_POS[AW-1:0];
      CFG_VEL:  cfg_wr.addr = R_VEL[AW-1:0];
      CFG_TIME: begin
        cfg_wr.addr = R_LT[AW-1:0];
        cfg_wr.data = {1'b0, cfg_data[62:0]};
      end
      CFG_PSTD: begin
        cfg_wr.addr = R_PSTD[AW-1:0];
        cfg_wr.data = {1'b0, cfg_data[62:0]};
      end
      CFG_ASTD: begin
        cfg_wr.addr = R_ASTD[AW-1:0];
        cfg_wr.data = {1'b0, cfg_data[62:0]};
      end
      default:  cfg_wr.we = 1'b0;
    endcase
  end

  // sequencer never writes while idle, which is when configuration arrives
  assign rf_wr = seq_wr.we ? seq_wr : cfg_wr;

  kpv_regfile u_rf (
    .clk   (clk),
    .rst_n (rst_n),
    .rd    (rf_rd),
    .wr    (rf_wr),
    .rd_a  (rd_a),
    .rd_b  (rd_b)
  );

  kpv_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  kpv_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_xfer),
    .entry    (in_operation ? PC_UPD : PC_PRD),
    .item     (item_r),
    .rd_a     (rd_a),
    .rd_b     (rd_b),
    .rd       (rf_rd),
    .wr       (seq_wr),
    .req      (alu_req),
    .rsp      (alu_rsp),
    .out_free (out_free),
    .fin      (fin),
    .idle     (seq_idle)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.load) begin
      out_pos_r  <= fin.pos;
      out_vel_r  <= fin.vel;
      out_skip_r <= fin.skip;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_estimated_position = out_pos_r;
  assign out_estimated_velocity = out_vel_r;
  assign out_update_skipped     = out_skip_r;

endmodule

[tb/kalman_position_velocity_axis_test.sv]
// Self-checking testbench for the single-axis position/velocity filter.
// Needs kpv_pkg and the kalman_position_velocity_axis RTL; nothing else.
// Carries its own Q31.32 filter model and checks every transfer on the result channel.
module kalman_position_velocity_axis_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [63:0] fx_t;
  typedef logic [62:0] ut_t;

  localparam fx_t FX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fx_t FX_MIN = 64'sh8000_0000_0000_0000;
  localparam fx_t ONE    = kpv_pkg::FX_ONE;
  localparam int  CYCLE_LIMIT = 4000000;

  typedef enum logic {OP_PREDICT = 1'b0, OP_UPDATE = 1'b1} op_e;

  typedef struct {
    op_e  op;
    fx_t  acc;
    ut_t  tnow;
    fx_t  zp;
    fx_t  zv;
    ut_t  pe;
    ut_t  ve;
  } gps_imu_item_t;

  typedef struct {
    fx_t  pos;
    fx_t  vel;
    logic skipped;
  } estimate_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = 1'b0;
  fx_t  in_acceleration = '0;
  ut_t  in_time_now = '0;
  fx_t  in_measured_position = '0;
  fx_t  in_measured_velocity = '0;
  ut_t  in_position_error = '0;
  ut_t  in_velocity_error = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fx_t  out_estimated_position;
  fx_t  out_estimated_velocity;
  logic out_update_skipped;
  logic cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  kalman_position_velocity_axis dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Filter model: saturating Q31.32 arithmetic and the two filter steps
  // ---------------------------------------------------------------------------
  fx_t est_pos, est_vel, pos_var;
  fx_t cov [4];
  fx_t prev_time;
  ut_t accel_sd;

  function automatic fx_t fx_add(fx_t a, fx_t b);
    fx_t r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) return a[63] ? FX_MIN : FX_MAX;
    return r;
  endfunction

  function automatic fx_t fx_sub(fx_t a, fx_t b);
    fx_t r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) return a[63] ? FX_MIN : FX_MAX;
    return r;
  endfunction

  function automatic logic [63:0] fx_mag(fx_t v);
    return v[63] ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic fx_t fx_clip(logic [63:0] m, logic neg, logic over);
    if (neg) return (over || m[63]) ? FX_MIN : -$signed(m);
    return (over || m[63]) ? FX_MAX : $signed(m);
  endfunction

  // exact product, round half away from zero on the magnitude, then clip
  function automatic fx_t fx_mul(fx_t a, fx_t b);
    logic [127:0] p;
    p = {64'd0, fx_mag(a)} * {64'd0, fx_mag(b)};
    p = p + (128'd1 << 31);
    return fx_clip(p[95:32], a[63] ^ b[63], |p[127:96]);
  endfunction

  // quotient truncated toward zero; divisor never zero here
  function automatic fx_t fx_div(fx_t n, fx_t d);
    logic [127:0] q;
    q = {32'd0, fx_mag(n), 32'd0} / {64'd0, fx_mag(d)};
    return fx_clip(q[63:0], n[63] ^ d[63], |q[127:64]);
  endfunction

  function automatic fx_t fx_sq(ut_t v);
    return fx_mul({1'b0, v}, {1'b0, v});
  endfunction

  task automatic model_predict(fx_t a, ut_t t);
    fx_t dt, sq, b0, q, x0, x1, m00, m01, m10, m11;
    dt  = $signed({1'b0, t}) - prev_time;
    sq  = fx_mul(dt, dt);
    b0  = {1'b0, sq[63:1]};
    q   = fx_sq(accel_sd);
    x0  = fx_add(fx_add(est_pos, fx_mul(dt, est_vel)), fx_mul(b0, a));
    x1  = fx_add(est_vel, fx_mul(dt, a));
    m00 = fx_add(cov[0], fx_mul(dt, cov[2]));
    m01 = fx_add(cov[1], fx_mul(dt, cov[3]));
    m10 = cov[2];
    m11 = cov[3];
    cov[0] = fx_add(fx_add(m00, fx_mul(m01, dt)), q);
    cov[1] = m01;
    cov[2] = fx_add(m10, fx_mul(m11, dt));
    cov[3] = fx_add(m11, q);
    est_pos = x0;
    est_vel = x1;
    prev_time = $signed({1'b0, t});
  endtask

  // returns 1 when the innovation covariance is singular
  function automatic logic model_update(fx_t zp, fx_t zv, ut_t pe, ut_t ve);
    fx_t s00, s01, s10, s11, det, i00, i01, i10, i11;
    fx_t k00, k01, k10, k11, y0, y1, n00, n01, n10, n11;
    fx_t np [4];
    if (pe != 0) pos_var = fx_sq(pe);
    s00 = fx_add(cov[0], pos_var);
    s01 = cov[1];
    s10 = cov[2];
    s11 = fx_add(cov[3], fx_sq(ve));
    det = fx_sub(fx_mul(s00, s11), fx_mul(s01, s10));
    if (det == 0) return 1'b1;
    i00 = fx_div(s11, det);
    i01 = fx_div(fx_sub('0, s01), det);
    i10 = fx_div(fx_sub('0, s10), det);
    i11 = fx_div(s00, det);
    k00 = fx_add(fx_mul(cov[0], i00), fx_mul(cov[1], i10));
    k01 = fx_add(fx_mul(cov[0], i01), fx_mul(cov[1], i11));
    k10 = fx_add(fx_mul(cov[2], i00), fx_mul(cov[3], i10));
    k11 = fx_add(fx_mul(cov[2], i01), fx_mul(cov[3], i11));
    y0  = fx_sub(zp, est_pos);
    y1  = fx_sub(zv, est_vel);
    est_pos = fx_add(est_pos, fx_add(fx_mul(k00, y0), fx_mul(k01, y1)));
    est_vel = fx_add(est_vel, fx_add(fx_mul(k10, y0), fx_mul(k11, y1)));
    n00 = fx_sub(ONE, k00);
    n01 = fx_sub('0, k01);
    n10 = fx_sub('0, k10);
    n11 = fx_sub(ONE, k11);
    np[0] = fx_add(fx_mul(n00, cov[0]), fx_mul(n01, cov[2]));
    np[1] = fx_add(fx_mul(n00, cov[1]), fx_mul(n01, cov[3]));
    np[2] = fx_add(fx_mul(n10, cov[0]), fx_mul(n11, cov[2]));
    np[3] = fx_add(fx_mul(n10, cov[1]), fx_mul(n11, cov[3]));
    for (int i = 0; i < 4; i++) cov[i] = np[i];
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Queues, counters and the mismatch report
  // ---------------------------------------------------------------------------
  gps_imu_item_t pending_items [$];
  estimate_t     expected_estimates [$];
  int errors = 0;
  int n_predicts = 0, n_updates = 0, n_skips = 0, n_results = 0;
  ut_t gen_time = '0;   // timestamp the generator believes the filter holds

  task automatic report_mismatch(string what);
    errors++;
    $display("MISMATCH %s", what);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of transfers with random gaps; the model runs on acceptance
  // ---------------------------------------------------------------------------
  gps_imu_item_t cur_item;
  int burst_left = 1, gap_left = 0;

  always @(posedge clk) begin
    estimate_t e;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (cur_item.op == OP_PREDICT) begin
          model_predict(cur_item.acc, cur_item.tnow);
          e.skipped = 1'b0;
          n_predicts++;
        end else begin
          e.skipped = model_update(cur_item.zp, cur_item.zv, cur_item.pe, cur_item.ve);
          n_updates++;
        end
        e.pos = est_pos;
        e.vel = est_vel;
        expected_estimates.push_back(e);
      end
      // payload may only move once the current transfer is done
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_valid             <= 1'b1;
          in_operation         <= cur_item.op;
          in_acceleration      <= cur_item.acc;
          in_time_now          <= cur_item.tnow;
          in_measured_position <= cur_item.zp;
          in_measured_velocity <= cur_item.zv;
          in_position_error    <= cur_item.pe;
          in_velocity_error    <= cur_item.ve;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            // a third of the bursts run straight on with no gap
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern changes every window; one long hold-off on request
  // ---------------------------------------------------------------------------
  logic hold_req = 1'b0;
  int hold_cnt = 0, window_left = 0, stall_mode = 0;

  always @(posedge clk) begin
    if (hold_req) begin
      hold_cnt = 4000;
      hold_req = 1'b0;
    end
    if (window_left == 0) begin
      window_left = $urandom_range(20, 400);
      stall_mode  = $urandom_range(0, 2);
    end
    window_left--;
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each result transfer against the oldest expected estimate
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    estimate_t e;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_estimates.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding", n_results));
      end else begin
        e = expected_estimates.pop_front();
        if (out_estimated_position !== e.pos)
          report_mismatch($sformatf("result %0d position: got %h expected %h",
                                    n_results, out_estimated_position, e.pos));
        if (out_estimated_velocity !== e.vel)
          report_mismatch($sformatf("result %0d velocity: got %h expected %h",
                                    n_results, out_estimated_velocity, e.vel));
        if (out_update_skipped !== e.skipped)
          report_mismatch($sformatf("result %0d skipped: got %b expected %b",
                                    n_results, out_update_skipped, e.skipped));
        if (e.skipped) n_skips++;
      end
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_estimates.size());
      $display("kalman_position_velocity_axis regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic fx_t rnd_small(int bits);
    logic [63:0] r;
    r = rnd64();
    return $signed(r) >>> (64 - bits);
  endfunction

  task automatic push_predict(fx_t a, ut_t t);
    gps_imu_item_t it;
    it.op = OP_PREDICT;  it.acc = a;  it.tnow = t;
    it.zp = rnd64();  it.zv = rnd64();  it.pe = ut_t'(rnd64());  it.ve = ut_t'(rnd64());
    pending_items.push_back(it);
    gen_time = t;
  endtask

  task automatic push_update(fx_t zp, fx_t zv, ut_t pe, ut_t ve);
    gps_imu_item_t it;
    it.op = OP_UPDATE;  it.acc = rnd64();  it.tnow = ut_t'(rnd64());
    it.zp = zp;  it.zv = zv;  it.pe = pe;  it.ve = ve;
    pending_items.push_back(it);
  endtask

  // Mostly plausible sensor traffic; wild mode lets every field of half the items
  // run free, timestamps included, which tends to saturate the covariance for good.
  task automatic push_random(int n, logic wild);
    int r;
    ut_t t;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (wild && r < 50) begin
        if ($urandom_range(0, 1)) push_predict(rnd64(), ut_t'(rnd64()));
        else push_update(rnd64(), rnd64(), ut_t'(rnd64()), ut_t'(rnd64()));
      end else if (r < 58) begin
        // noise: full-width content, but time still moves sensibly
        t = gen_time + $urandom_range(0, 1 << 30);
        if ($urandom_range(0, 1)) push_predict(rnd64(), t);
        else push_update(rnd64(), rnd64(), ut_t'(rnd64()), ut_t'(rnd64()));
      end else if (r < 79) begin
        // occasional small step backwards in time
        if (r < 62 && gen_time > (1 << 28)) t = gen_time - $urandom_range(1, 1 << 28);
        else t = gen_time + $urandom_range(0, 1 << 30);
        push_predict(rnd_small(37), t);
      end else begin
        push_update(rnd_small(45), rnd_small(39),
                    ($urandom_range(0, 3) == 0) ? ut_t'(0) : ut_t'(rnd64() >> 30),
                    ut_t'(rnd64() >> 30));
      end
    end
  endtask

  // all results in, then a margin for the last one to clear the output stage
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_estimates.size() != 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      kpv_pkg::CFG_POS:  est_pos = data;
      kpv_pkg::CFG_VEL:  est_vel = data;
      kpv_pkg::CFG_TIME: begin
        prev_time = {1'b0, data[62:0]};
        gen_time  = data[62:0];
      end
      kpv_pkg::CFG_PSTD: pos_var = fx_sq(data[62:0]);
      kpv_pkg::CFG_ASTD: accel_sd = data[62:0];
      default: ;
    endcase
  endtask

  task automatic configure(fx_t pos, fx_t vel, ut_t t0, ut_t psd, ut_t asd);
    write_reg(kpv_pkg::CFG_POS, pos);
    write_reg(kpv_pkg::CFG_VEL, vel);
    write_reg(kpv_pkg::CFG_TIME, {1'b0, t0});
    write_reg(kpv_pkg::CFG_PSTD, {1'b0, psd});
    write_reg(kpv_pkg::CFG_ASTD, {1'b0, asd});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    est_pos = '0;  est_vel = '0;  pos_var = '0;  prev_time = '0;  accel_sd = '0;
    cov[0] = ONE;  cov[1] = '0;  cov[2] = '0;  cov[3] = ONE;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: zero noise makes K the identity and drives P to zero,
    // so the following updates see a singular S and are skipped.
    push_update(64'sd5 <<< 32, 64'sd1 <<< 32, '0, '0);
    push_update(-(64'sd7 <<< 32), 64'sd2 <<< 32, '0, '0);
    push_predict(ONE, 63'd1 << 32);
    push_update(64'sd3 <<< 32, '0, '0, '0);
    wait_idle();

    // Plausible settings, directed cases first.
    configure(64'sd1000 <<< 32, -(64'sd3 <<< 32), 63'd5 << 32, 63'd2 << 32, 63'd1 << 31);
    push_predict(ONE, 63'd6 << 32);
    push_update(64'sd1004 <<< 32, -(64'sd2 <<< 32), 63'd3 << 32, 63'd1 << 31);
    push_update(64'sd1003 <<< 32, '0, '0, 63'd1 << 30);                 // keeps variance
    push_update(64'sd1003 <<< 32, FX_MAX, 63'd1 << 32, {63{1'b1}});      // huge R11
    push_predict(FX_MAX, 63'd7 << 32);
    push_predict(FX_MIN, 63'd7 << 32);                                   // dt of zero
    push_update(FX_MIN, FX_MAX, 63'd1 << 32, 63'd1 << 32);
    push_predict('0, 63'd6 << 32);                                       // time backwards
    push_random(420, 1'b0);
    wait_idle();

    // Long hold-off on the receiver while the sender keeps offering items.
    configure(rnd_small(50), rnd_small(40), ut_t'($urandom_range(0, 1000)) << 32,
              ut_t'(rnd64() >> 30), ut_t'(rnd64() >> 33));
    hold_req = 1'b1;
    push_random(420, 1'b0);
    wait_idle();

    // Extremes: full-scale registers and fields, then free-running noise.
    configure(FX_MAX, FX_MIN, {63{1'b1}}, {63{1'b1}}, {63{1'b1}});
    push_predict(FX_MAX, '0);
    push_update(FX_MAX, FX_MIN, {63{1'b1}}, '0);
    push_predict(FX_MIN, {63{1'b1}});
    push_update(FX_MIN, FX_MAX, '0, {63{1'b1}});
    push_random(120, 1'b1);
    wait_idle();

    configure('0, '0, '0, '0, '0);
    push_predict('0, '0);
    push_update('0, '0, '0, '0);
    push_random(40, 1'b1);
    wait_idle();

    repeat (800) @(posedge clk);
    if (expected_estimates.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_estimates.size()));
    end
    $display("covered %0d predicts and %0d updates (%0d skipped as singular), %0d results",
             n_predicts, n_updates, n_skips, n_results);
    $display("five register settings incl. extremes, long output stall, %0d cycles", cycles);
    if (errors == 0) begin
      $display("kalman_position_velocity_axis regression: pass");
    end else begin
      $display("kalman_position_velocity_axis regression: fail");
    end
    $finish;
  end

endmodule
